// ===== rtl/hkt_pkg.sv =====
// ----------------------------------------------------------------------------
// hkt_pkg
// shared types and constants of the held key tracker
// ----------------------------------------------------------------------------
package hkt_pkg;

    localparam int TRACK_DEPTH  = 16;
    localparam int RESULT_LIMIT = 16;

    localparam int ROW_W     = 5;
    localparam int COL_W     = 5;
    localparam int PKT_W     = 11;
    localparam int ROW_LSB   = 0;
    localparam int COL_LSB   = 5;
    localparam int PRESS_BIT = 10;

    localparam int CNT_W   = $clog2(TRACK_DEPTH + 1);
    localparam int LIMIT_N = (RESULT_LIMIT < TRACK_DEPTH) ? RESULT_LIMIT : TRACK_DEPTH;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } entry_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_ROTATE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        entry_t    key;
    } cell_ctrl_t;

endpackage

// ===== rtl/hkt_in_if.sv =====
// ----------------------------------------------------------------------------
// hkt_in_if
// input channel: key packet or scan tick
// ----------------------------------------------------------------------------
interface hkt_in_if;

    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [hkt_pkg::PKT_W-1:0] raw_packet;

    modport source (output valid, output kind, output raw_packet, input ready);
    modport sink   (input valid, input kind, input raw_packet, output ready);

endinterface

// ===== rtl/hkt_out_if.sv =====
// ----------------------------------------------------------------------------
// hkt_out_if
// output channel: key events
// ----------------------------------------------------------------------------
interface hkt_out_if;

    logic                      valid;
    logic                      ready;
    logic [hkt_pkg::ROW_W-1:0] key_row;
    logic [hkt_pkg::COL_W-1:0] key_col;
    logic                      is_press;
    logic                      last_event;

    modport source (output valid, output key_row, output key_col, output is_press,
                    output last_event, input ready);
    modport sink   (input valid, input key_row, input key_col, input is_press,
                    input last_event, output ready);

endinterface

// ===== rtl/hkt_cell.sv =====
// ----------------------------------------------------------------------------
// hkt_cell
// one table slot: holds a key, compares it, and shifts toward either neighbor
// ----------------------------------------------------------------------------
module hkt_cell (
    input  logic                clk,
    input  hkt_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  hkt_pkg::entry_t     left,
    input  hkt_pkg::entry_t     right,
    input  logic                hit_in,
    output logic                hit_out,
    output logic                match,
    output hkt_pkg::entry_t     data
);

    hkt_pkg::entry_t data_reg;
    hkt_pkg::entry_t data_next;

    assign match   = occupied && (data_reg == ctrl.key);
    assign hit_out = hit_in | match;
    assign data    = data_reg;

    always_comb
    begin
        unique case (ctrl.cmd)
            hkt_pkg::CMD_INSERT: data_next = left;
            hkt_pkg::CMD_ROTATE: data_next = right;
            hkt_pkg::CMD_REMOVE: data_next = hit_out ? right : data_reg;
            default:             data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== rtl/held_key_tracker.sv =====
// ----------------------------------------------------------------------------
// held_key_tracker
// ordered table of held keys built as a row of shifting cells
// ----------------------------------------------------------------------------
// in_ch carries either a key packet (kind 0: row, column, pressed flag) or a
// scan tick (kind 1). out_ch carries key events with row, column, is_press and
// a last_event mark on the final event of each input item.
// A packet is accepted in ST_IDLE; in ST_EXEC every cell compares its key in
// parallel and the row shifts to insert or remove.
// A scan tick rotates the row one cell per cycle (held while an event waits for
// the output register) through a full turn; the head cell feeds the output, so
// every held key is sent newest first and the table ends in its original order.
// One item is in work at a time; in_ch.ready is high when the block is idle,
// and an item is accepted while the last event still waits in the output
// register. When the receiver stalls, the rotation and the table update wait
// until the output register frees up; nothing is lost.
// Reset empties the table (entry count zero) and clears the output valid flag;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module held_key_tracker (
    input  logic          clk,
    input  logic          rst_n,
    hkt_in_if.sink        in_ch,
    hkt_out_if.source     out_ch
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [hkt_pkg::CNT_W-1:0] count_reg, count_next;
    logic [hkt_pkg::CNT_W-1:0] step_reg, step_next;
    hkt_pkg::entry_t           key_reg, key_next;
    logic                      press_reg, press_next;

    logic                      out_valid_reg, out_valid_next;
    hkt_pkg::entry_t           out_key_reg, out_key_next;
    logic                      out_press_reg, out_press_next;
    logic                      out_last_reg, out_last_next;

    hkt_pkg::cell_ctrl_t                   ctrl;
    hkt_pkg::entry_t                       cell_data [hkt_pkg::TRACK_DEPTH];
    logic [hkt_pkg::TRACK_DEPTH:0]         hit_chain;
    logic [hkt_pkg::TRACK_DEPTH-1:0]       match_vec;

    logic                      in_acc;
    logic                      o_free;
    logic                      hit;
    logic                      full;
    logic [hkt_pkg::CNT_W-1:0] scan_n;
    logic                      emitting;
    logic                      load_out;

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < hkt_pkg::TRACK_DEPTH; i++)
    begin : g_cell
        hkt_pkg::entry_t left_d;
        hkt_pkg::entry_t right_d;

        if (i == 0)
        begin : g_head
            assign left_d = key_reg;
        end
        else
        begin : g_body
            assign left_d = cell_data[i-1];
        end

        if (i == hkt_pkg::TRACK_DEPTH - 1)
        begin : g_tail
            assign right_d = cell_data[0];
        end
        else
        begin : g_mid
            assign right_d = cell_data[i+1];
        end

        hkt_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .occupied (hkt_pkg::CNT_W'(i) < count_reg),
            .left     (left_d),
            .right    (right_d),
            .hit_in   (hit_chain[i]),
            .hit_out  (hit_chain[i+1]),
            .match    (match_vec[i]),
            .data     (cell_data[i])
        );
    end

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign in_acc            = in_ch.valid && in_ch.ready;
    assign o_free            = !out_valid_reg || out_ch.ready;
    assign hit               = hit_chain[hkt_pkg::TRACK_DEPTH];
    assign full              = (count_reg == hkt_pkg::CNT_W'(hkt_pkg::TRACK_DEPTH));
    assign scan_n            = (count_reg > hkt_pkg::CNT_W'(hkt_pkg::LIMIT_N))
                               ? hkt_pkg::CNT_W'(hkt_pkg::LIMIT_N) : count_reg;
    assign emitting          = (step_reg < scan_n);

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.key_row    = out_key_reg.row;
    assign out_ch.key_col    = out_key_reg.col;
    assign out_ch.is_press   = out_press_reg;
    assign out_ch.last_event = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        key_next       = key_reg;
        press_next     = press_reg;
        out_key_next   = out_key_reg;
        out_press_next = out_press_reg;
        out_last_next  = out_last_reg;
        load_out       = 1'b0;
        ctrl.key       = key_reg;
        ctrl.cmd       = hkt_pkg::CMD_HOLD;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    key_next.row = in_ch.raw_packet[hkt_pkg::ROW_LSB +: hkt_pkg::ROW_W];
                    key_next.col = in_ch.raw_packet[hkt_pkg::COL_LSB +: hkt_pkg::COL_W];
                    press_next   = in_ch.raw_packet[hkt_pkg::PRESS_BIT];
                    step_next    = '0;
                    state_next   = in_ch.kind ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!(hit || (press_reg && !full)))
                begin
                    state_next = ST_IDLE;
                end
                else if (o_free)
                begin
                    load_out       = 1'b1;
                    out_key_next   = key_reg;
                    out_press_next = press_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                    if (press_reg && !hit)
                    begin
                        ctrl.cmd   = hkt_pkg::CMD_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                    else if (!press_reg)
                    begin
                        ctrl.cmd   = hkt_pkg::CMD_REMOVE;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!emitting || o_free)
                begin
                    ctrl.cmd  = hkt_pkg::CMD_ROTATE;
                    step_next = step_reg + 1'b1;
                    if (emitting)
                    begin
                        load_out       = 1'b1;
                        out_key_next   = cell_data[0];
                        out_press_next = 1'b1;
                        out_last_next  = (step_reg + 1'b1 == scan_n);
                    end
                    if (step_reg == hkt_pkg::CNT_W'(hkt_pkg::TRACK_DEPTH - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        press_reg     <= press_next;
        out_key_reg   <= out_key_next;
        out_press_reg <= out_press_next;
        out_last_reg  <= out_last_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hkt_pkg::CNT_W'(hkt_pkg::TRACK_DEPTH))
        else $error("entry count beyond table depth");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $onehot0(match_vec))
        else $error("key held in more than one cell");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cmd == hkt_pkg::CMD_INSERT) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the table");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cmd == hkt_pkg::CMD_REMOVE) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not shrink the table");

    a_scan_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> $stable(count_reg))
        else $error("table size changed during a scan");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the held key tracker
// ----------------------------------------------------------------------------
// Key packets and scan ticks go into in_ch. A tracker table kept in the bench
// gives the key events that each accepted item must produce. Every event seen
// on out_ch is compared with the oldest pending event. Both sides idle at
// random, apart from one steady stretch. The stimulus covers an empty table,
// repeated presses, releases of keys that are not held, a full table that
// drops presses, full-length scan bursts, and random traffic over a small
// set of keys.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int BURST_MAX   = (hkt_pkg::RESULT_LIMIT < hkt_pkg::TRACK_DEPTH)
                                 ? hkt_pkg::RESULT_LIMIT : hkt_pkg::TRACK_DEPTH;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic [hkt_pkg::ROW_W-1:0] row;
        logic [hkt_pkg::COL_W-1:0] col;
        logic                      press;
        logic                      last;
    } key_event_t;

    logic clk;
    logic rst_n;

    hkt_in_if  in_ch ();
    hkt_out_if out_ch ();

    held_key_tracker i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    hkt_pkg::entry_t held_keys [hkt_pkg::TRACK_DEPTH];
    int              held_count;
    hkt_pkg::entry_t key_pool [POOL_SIZE];
    key_event_t      pending_events [$];

    bit no_idle;
    int error_count;
    int items_sent;
    int ticks_sent;
    int events_predicted;
    int events_checked;
    int full_bursts;
    int cycle_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // tracker table of the bench
    // ------------------------------------------------------------------------
    function automatic logic [hkt_pkg::PKT_W-1:0] make_packet(
        input logic [hkt_pkg::ROW_W-1:0] row,
        input logic [hkt_pkg::COL_W-1:0] col,
        input logic press);
        logic [hkt_pkg::PKT_W-1:0] pkt;
        pkt = '0;
        pkt[hkt_pkg::ROW_LSB +: hkt_pkg::ROW_W] = row;
        pkt[hkt_pkg::COL_LSB +: hkt_pkg::COL_W] = col;
        pkt[hkt_pkg::PRESS_BIT]                 = press;
        return pkt;
    endfunction

    function automatic int find_held(input hkt_pkg::entry_t key);
        for (int i = 0; i < held_count; i++)
        begin
            if (held_keys[i] == key)
                return i;
        end
        return -1;
    endfunction

    task automatic track_key_item(input logic kind, input logic [hkt_pkg::PKT_W-1:0] pkt);
        hkt_pkg::entry_t key;
        logic            press;
        int              idx;
        int              n;
        key_event_t      ev;
        begin
            if (kind)
            begin
                n = (held_count < BURST_MAX) ? held_count : BURST_MAX;
                if (n == BURST_MAX)
                    full_bursts++;
                for (int i = 0; i < n; i++)
                begin
                    ev.row   = held_keys[i].row;
                    ev.col   = held_keys[i].col;
                    ev.press = 1'b1;
                    ev.last  = (i == n - 1);
                    pending_events.push_back(ev);
                    events_predicted++;
                end
            end
            else
            begin
                key.row = pkt[hkt_pkg::ROW_LSB +: hkt_pkg::ROW_W];
                key.col = pkt[hkt_pkg::COL_LSB +: hkt_pkg::COL_W];
                press   = pkt[hkt_pkg::PRESS_BIT];
                idx     = find_held(key);
                ev.row  = key.row;
                ev.col  = key.col;
                ev.last = 1'b1;
                if (press)
                begin
                    if (idx < 0 && held_count < hkt_pkg::TRACK_DEPTH)
                    begin
                        for (int i = held_count; i > 0; i--)
                            held_keys[i] = held_keys[i-1];
                        held_keys[0] = key;
                        held_count++;
                    end
                    if (idx >= 0 || held_count <= hkt_pkg::TRACK_DEPTH && find_held(key) >= 0)
                    begin
                        ev.press = 1'b1;
                        pending_events.push_back(ev);
                        events_predicted++;
                    end
                end
                else if (idx >= 0)
                begin
                    ev.press = 1'b0;
                    pending_events.push_back(ev);
                    events_predicted++;
                    for (int i = idx; i < held_count - 1; i++)
                        held_keys[i] = held_keys[i+1];
                    held_count--;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [hkt_pkg::PKT_W-1:0] pkt);
        begin
            while (!no_idle && $urandom_range(0, 99) < 34)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
            end
            @(negedge clk);
            in_ch.valid      <= 1'b1;
            in_ch.kind       <= kind;
            in_ch.raw_packet <= pkt;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            track_key_item(kind, pkt);
            items_sent++;
            if (kind)
                ticks_sent++;
        end
    endtask

    task automatic send_tick();
        begin
            send_item(1'b1, hkt_pkg::PKT_W'($urandom_range(0, (1 << hkt_pkg::PKT_W) - 1)));
        end
    endtask

    // one well-formed or noisy item; returns 1 if it produced events
    task automatic send_random_item(output bit active);
        int                        events_at_start;
        int                        pick;
        hkt_pkg::entry_t           key;
        logic [hkt_pkg::PKT_W-1:0] pkt;
        begin
            events_at_start = events_predicted;
            pick            = $urandom_range(0, 99);
            if (pick < 15)
                send_tick();
            else if (pick < 55 || (pick < 85 && held_count == 0))
            begin
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_item(1'b0, make_packet(key.row, key.col, 1'b1));
            end
            else if (pick < 85)
            begin
                key = held_keys[$urandom_range(0, held_count - 1)];
                send_item(1'b0, make_packet(key.row, key.col, 1'b0));
            end
            else if (pick < 93)
            begin
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_item(1'b0, make_packet(key.row, key.col, 1'b0));
            end
            else
            begin
                pkt = hkt_pkg::PKT_W'($urandom_range(0, (1 << hkt_pkg::PKT_W) - 1));
                send_item(1'b0, pkt);
            end
            active = (events_predicted != events_at_start);
        end
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
            error_count++;
        end
    endtask

    always @(negedge clk)
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 34);

    always @(posedge clk)
    begin : check_events
        key_event_t seen;
        key_event_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen.row   = out_ch.key_row;
            seen.col   = out_ch.key_col;
            seen.press = out_ch.is_press;
            seen.last  = out_ch.last_event;
            if (pending_events.size() == 0)
                report_mismatch($sformatf("unexpected event row %0d col %0d press %0b last %0b",
                                          seen.row, seen.col, seen.press, seen.last));
            else
            begin
                want = pending_events.pop_front();
                events_checked++;
                if (seen.row !== want.row || seen.col !== want.col ||
                    seen.press !== want.press || seen.last !== want.last)
                    report_mismatch($sformatf(
                        "got row %0d col %0d press %0b last %0b, want %0d %0d %0b %0b",
                        seen.row, seen.col, seen.press, seen.last,
                        want.row, want.col, want.press, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events pending",
                     cycle_count, pending_events.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic build_key_pool();
        hkt_pkg::entry_t key;
        bit              dup;
        begin
            key_pool[0] = '{row: '0, col: '1};
            key_pool[1] = '{row: '1, col: '0};
            for (int i = 2; i < POOL_SIZE; i++)
            begin
                do
                begin
                    key.row = hkt_pkg::ROW_W'($urandom_range(0, 31));
                    key.col = hkt_pkg::COL_W'($urandom_range(0, 31));
                    dup = 1'b0;
                    for (int j = 0; j < i; j++)
                        if (key_pool[j] == key)
                            dup = 1'b1;
                end
                while (dup);
                key_pool[i] = key;
            end
        end
    endtask

    task automatic test_basic_events();
        begin
            send_item(1'b1, '1);
            send_item(1'b0, make_packet(5'd0, 5'd0, 1'b1));
            send_item(1'b0, make_packet(5'd31, 5'd31, 1'b1));
            send_item(1'b0, make_packet(5'd31, 5'd31, 1'b1));
            send_item(1'b0, make_packet(5'd5, 5'd7, 1'b0));
            send_item(1'b1, '0);
            send_item(1'b0, make_packet(5'd0, 5'd0, 1'b0));
        end
    endtask

    task automatic test_full_table();
        begin
            for (int i = 1; i < hkt_pkg::TRACK_DEPTH; i++)
                send_item(1'b0, make_packet(hkt_pkg::ROW_W'(i), hkt_pkg::COL_W'(31 - i), 1'b1));
            send_item(1'b0, make_packet(5'd20, 5'd20, 1'b1));
            send_tick();
            send_item(1'b0, make_packet(5'd8, 5'd23, 1'b0));
        end
    endtask

    task automatic test_steady_stream();
        int active_items;
        bit active;
        begin
            no_idle      = 1'b1;
            active_items = 0;
            while (active_items < 50)
            begin
                send_random_item(active);
                if (active)
                    active_items++;
            end
            no_idle = 1'b0;
        end
    endtask

    task automatic test_random_traffic();
        int active_items;
        bit active;
        begin
            active_items = 0;
            while (active_items < 270)
            begin
                send_random_item(active);
                if (active)
                    active_items++;
            end
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = 1'b0;
        in_ch.raw_packet = '0;
        out_ch.ready     = 1'b0;
        no_idle          = 1'b0;
        error_count      = 0;
        items_sent       = 0;
        ticks_sent       = 0;
        events_predicted = 0;
        events_checked   = 0;
        full_bursts      = 0;
        cycle_count      = 0;
        held_count       = 0;
        build_key_pool();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_basic_events();
        test_full_table();
        test_random_traffic();
        test_steady_stream();

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (hkt_pkg::TRACK_DEPTH + 8) @(posedge clk);
        if (pending_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", pending_events.size()));

        $display("sent %0d items (%0d scan ticks, %0d full-length bursts)",
                 items_sent, ticks_sent, full_bursts);
        $display("checked %0d key events, %0d mismatches", events_checked, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
